[sv/nfcs_pkg.sv]
// Shared types and constants for the NOR flash command sequencer.
`timescale 1ns / 1ps

package nfcs_pkg;

    // Buffer program depth in words; word counts clamp to 1..BUFFER_WORDS
    localparam int BUFFER_WORDS = 32;

    localparam int OFS_W   = 26;
    localparam int ADDR_W  = 31;
    localparam int DATA_W  = 16;
    localparam int CNT_W   = 6;
    localparam int STEP_W  = 3;
    localparam int BANK_W  = 2;
    localparam int INDEX_W = 2;

    // Command opcodes
    typedef enum logic [3:0] {
        OP_TO_READ     = 4'd0,
        OP_ID          = 4'd1,
        OP_CFI         = 4'd2,
        OP_RESET_READ  = 4'd3,
        OP_READ        = 4'd4,
        OP_PROGRAM     = 4'd5,
        OP_BUF_START   = 4'd6,
        OP_BUF_WORD    = 4'd7,
        OP_BUF_CONFIRM = 4'd8,
        OP_ERASE_BLOCK = 4'd9,
        OP_ERASE_CHIP  = 4'd10
    } op_t;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_BANK_SELECT  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WIDE_BUS     = 2'd1;
    localparam logic [INDEX_W-1:0] REG_WRITE_ENABLE = 2'd2;

    // Command-cycle addresses (device word offsets)
    localparam logic [11:0] CA_555 = 12'h555;
    localparam logic [11:0] CA_2AA = 12'h2AA;
    localparam logic [11:0] CA_055 = 12'h055;

    // Command-cycle data
    localparam logic [DATA_W-1:0] CD_UNLOCK1  = 16'h00AA;
    localparam logic [DATA_W-1:0] CD_UNLOCK2  = 16'h0055;
    localparam logic [DATA_W-1:0] CD_AUTOSEL  = 16'h0090;
    localparam logic [DATA_W-1:0] CD_PROGRAM  = 16'h00A0;
    localparam logic [DATA_W-1:0] CD_ERASE    = 16'h0080;
    localparam logic [DATA_W-1:0] CD_CHIP     = 16'h0010;
    localparam logic [DATA_W-1:0] CD_CFI      = 16'h0098;
    localparam logic [DATA_W-1:0] CD_BUF_LOAD = 16'h0025;
    localparam logic [DATA_W-1:0] CD_BUF_PROG = 16'h0029;
    localparam logic [DATA_W-1:0] CD_SECTOR   = 16'h0030;
    localparam logic [DATA_W-1:0] CD_RESET    = 16'h00F0;

    // Address source for one access
    typedef enum logic [1:0] {
        SRC_BASE,
        SRC_CMD,
        SRC_PLAIN
    } src_t;

    // Command held while its accesses go out
    typedef struct packed {
        logic [3:0]        op;
        logic              rej;
        logic [OFS_W-1:0]  ofs;
        logic [DATA_W-1:0] word;
        logic [CNT_W-1:0]  cnt_m1;
    } cmd_t;

    // One bus access
    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              rejected;
    } access_t;

endpackage

[sv/nor_flash_command_sequencer.sv]
// Top level of the NOR flash command sequencer: command register, step counter, output register.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid / in_stall) takes one flash command: opcode,
//   target_offset, write_word, word_count. Opcodes above erase_chip are
//   accepted and dropped without any access.
// - Output channel (out_valid / out_stall) gives the bus accesses of a
//   command in order, one per cycle while out_stall is low; last_access marks the final one.
// - The accepted request lands in the command register; its first access
//   goes from there into the output register once that register is free.
// - Occupancy: a command occupies the step counter for one step per access,
//   1 to 7 accesses (id has 7, erase 6). The next request is taken
//   in the cycle the current command's last access enters the output
//   register, so commands run back to back with no gap.
// - When the receiver stalls, the output register holds its access and the
//   step counter waits; the input stalls while a held command's last access cannot issue.
// - Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no command is in flight.
// - Reset clears the pipeline, selects bank 0, 16-bit bus, writes enabled,
//   and clears the last loaded buffer offset.
module nor_flash_command_sequencer
    import nfcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Command input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          opcode,
    input  logic [OFS_W-1:0]    target_offset,
    input  logic [DATA_W-1:0]   write_word,
    input  logic [CNT_W-1:0]    word_count,
    // Bus access output
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_write,
    output logic [ADDR_W-1:0]   bus_address,
    output logic [DATA_W-1:0]   bus_data,
    output logic                last_access,
    output logic                rejected,
    // Configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [1:0]          cfg_data
);

    logic [BANK_W-1:0] bank_reg;
    logic              wide_reg;
    logic              wen_reg;
    logic [OFS_W-1:0]  loaded_reg, loaded_next;
    logic              cmd_valid_reg, cmd_valid_next;
    cmd_t              cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    access_t           out_reg, out_next;

    access_t           acc;
    logic              advance;
    logic              accept;
    logic              known_op;
    logic              op_rej;
    logic [CNT_W-1:0]  cnt_clamp;

    assign cfg_ready = 1'b1;

    nfcs_access u_access (
        .cmd         (cmd_reg),
        .step        (step_reg),
        .bank_select (bank_reg),
        .wide_bus    (wide_reg),
        .acc         (acc)
    );

    // Issue an access when a command is held and the output slot frees up
    assign advance  = cmd_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = cmd_valid_reg && !(advance && acc.last);
    assign accept   = in_valid && !in_stall;

    assign known_op = (opcode <= 4'(OP_ERASE_CHIP));
    assign op_rej   = (opcode >= 4'(OP_PROGRAM)) && !wen_reg;

    // Clamp the buffer word count to the buffer depth
    always_comb
    begin
        priority if (word_count == '0)
            cnt_clamp = CNT_W'(1);
        else if (word_count > CNT_W'(BUFFER_WORDS))
            cnt_clamp = CNT_W'(BUFFER_WORDS);
        else
            cnt_clamp = word_count;
    end

    // Next state of command register, step counter and output register
    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        loaded_next    = loaded_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = acc;
            if (acc.last)
            begin
                cmd_valid_next = 1'b0;
                step_next      = '0;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end

        if (accept && known_op)
        begin
            cmd_valid_next = 1'b1;
            step_next      = '0;
            cmd_next.op     = opcode;
            cmd_next.rej    = op_rej;
            cmd_next.ofs    = (opcode == 4'(OP_BUF_CONFIRM)) ? loaded_reg : target_offset;
            cmd_next.word   = write_word;
            cmd_next.cnt_m1 = cnt_clamp - CNT_W'(1);
            if (!op_rej && (opcode == 4'(OP_BUF_START) || opcode == 4'(OP_BUF_WORD)))
                loaded_next = target_offset;
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            loaded_reg    <= '0;
            bank_reg      <= '0;
            wide_reg      <= 1'b1;
            wen_reg       <= 1'b1;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            loaded_reg    <= loaded_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BANK_SELECT:  bank_reg <= cfg_data;
                    REG_WIDE_BUS:     wide_reg <= cfg_data[0];
                    REG_WRITE_ENABLE: wen_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_write    = out_reg.is_write;
    assign bus_address = out_reg.addr;
    assign bus_data    = out_reg.data;
    assign last_access = out_reg.last;
    assign rejected    = out_reg.rejected;

    // The input stalls only while a command is held
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> cmd_valid_reg)
        else $error("input stalled with no command held");

    // An idle step counter rests at zero
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid_reg |-> (step_reg == '0))
        else $error("step counter nonzero while idle");

    // No command runs past seven accesses
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(6))
        else $error("step counter out of range");

    // A rejection is a single read that ends its command
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (last_access && !is_write && bus_data == '0))
        else $error("malformed rejection");

endmodule

[sv/nfcs_access.sv]
// Access generator: maps the held command and step number to one bus access.
`timescale 1ns / 1ps

module nfcs_access
    import nfcs_pkg::*;
(
    input  cmd_t                cmd,
    input  logic [STEP_W-1:0]   step,
    input  logic [BANK_W-1:0]   bank_select,
    input  logic                wide_bus,
    output access_t             acc
);

    src_t              src;
    logic [11:0]       ca;
    logic [DATA_W-1:0] data;
    logic              wr;
    logic              last;
    logic [OFS_W-1:0]  ca_ofs;
    logic [OFS_W-1:0]  low;

    // Select address source, data and end of run for this step
    always_comb
    begin
        src  = SRC_CMD;
        ca   = CA_555;
        data = '0;
        wr   = 1'b1;
        last = 1'b0;
        if (cmd.rej)
        begin
            src  = SRC_BASE;
            wr   = 1'b0;
            last = 1'b1;
        end
        else
        begin
            unique case (op_t'(cmd.op))
                OP_TO_READ:
                begin
                    src  = SRC_BASE;
                    data = CD_RESET;
                    last = 1'b1;
                end
                OP_ID:
                begin
                    unique case (step)
                        3'd0: data = CD_UNLOCK1;
                        3'd1: begin ca = CA_2AA; data = CD_UNLOCK2; end
                        3'd2: data = CD_AUTOSEL;
                        3'd3: begin ca = 12'h000; wr = 1'b0; end
                        3'd4: begin ca = 12'h001; wr = 1'b0; end
                        3'd5: begin ca = 12'h00E; wr = 1'b0; end
                        default: begin ca = 12'h00F; wr = 1'b0; last = 1'b1; end
                    endcase
                end
                OP_CFI:
                begin
                    if (step == 3'd0)
                    begin
                        ca   = CA_055;
                        data = CD_CFI;
                    end
                    else
                    begin
                        ca   = 12'h060 + {9'd0, step};
                        wr   = 1'b0;
                        last = (step == 3'd4);
                    end
                end
                OP_RESET_READ:
                begin
                    unique case (step)
                        3'd0: data = CD_UNLOCK1;
                        3'd1: begin ca = CA_2AA; data = CD_UNLOCK2; end
                        default: begin data = CD_RESET; last = 1'b1; end
                    endcase
                end
                OP_READ:
                begin
                    src  = SRC_PLAIN;
                    wr   = 1'b0;
                    last = 1'b1;
                end
                OP_PROGRAM:
                begin
                    unique case (step)
                        3'd0: data = CD_UNLOCK1;
                        3'd1: begin ca = CA_2AA; data = CD_UNLOCK2; end
                        3'd2: data = CD_PROGRAM;
                        default: begin src = SRC_PLAIN; data = cmd.word; last = 1'b1; end
                    endcase
                end
                OP_BUF_START:
                begin
                    unique case (step)
                        3'd0: data = CD_UNLOCK1;
                        3'd1: begin ca = CA_2AA; data = CD_UNLOCK2; end
                        3'd2: begin src = SRC_PLAIN; data = CD_BUF_LOAD; end
                        default:
                        begin
                            src  = SRC_PLAIN;
                            data = {{(DATA_W-CNT_W){1'b0}}, cmd.cnt_m1};
                            last = 1'b1;
                        end
                    endcase
                end
                OP_BUF_WORD:
                begin
                    src  = SRC_PLAIN;
                    data = cmd.word;
                    last = 1'b1;
                end
                OP_BUF_CONFIRM:
                begin
                    src  = SRC_PLAIN;
                    data = CD_BUF_PROG;
                    last = 1'b1;
                end
                OP_ERASE_BLOCK, OP_ERASE_CHIP:
                begin
                    unique case (step)
                        3'd0, 3'd3: data = CD_UNLOCK1;
                        3'd1, 3'd4: begin ca = CA_2AA; data = CD_UNLOCK2; end
                        3'd2: data = CD_ERASE;
                        default:
                        begin
                            last = 1'b1;
                            if (op_t'(cmd.op) == OP_ERASE_BLOCK)
                            begin
                                src  = SRC_PLAIN;
                                data = CD_SECTOR;
                            end
                            else
                            begin
                                data = CD_CHIP;
                            end
                        end
                    endcase
                end
                default:
                begin
                    // Unknown opcodes never reach the command register
                    src  = SRC_BASE;
                    wr   = 1'b0;
                    last = 1'b1;
                end
            endcase
        end
    end

    // Shift command addresses on a 16-bit device
    assign ca_ofs = wide_bus ? {{(OFS_W-13){1'b0}}, ca, 1'b0}
                             : {{(OFS_W-12){1'b0}}, ca};

    // Offset within the bank; the base has no bits below the bank field
    always_comb
    begin
        unique case (src)
            SRC_CMD:   low = ca_ofs;
            SRC_PLAIN: low = cmd.ofs;
            default:   low = '0;
        endcase
    end

    assign acc.is_write = wr;
    assign acc.addr     = {3'b110, bank_select, low};
    assign acc.data     = wr ? data : '0;
    assign acc.last     = last;
    assign acc.rejected = cmd.rej;

endmodule

[tb/nor_flash_command_sequencer_tb.sv]
// Self-checking testbench for the NOR flash command sequencer: directed table, then random phases.
`timescale 1ns / 1ps

module nor_flash_command_sequencer_tb
    import nfcs_pkg::*;
();

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    // Cycles to let a dropped opcode or a final access clear the pipeline
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 56;
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // One directed step: a register write or a command
    typedef struct {
        bit                 is_cfg;
        logic [INDEX_W-1:0] reg_idx;
        logic [1:0]         reg_val;
        logic [3:0]         op;
        logic [OFS_W-1:0]   ofs;
        logic [DATA_W-1:0]  word;
        logic [CNT_W-1:0]   cnt;
        bit                 typed;
        access_t            want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] opcode = '0;
    logic [OFS_W-1:0] target_offset = '0;
    logic [DATA_W-1:0] write_word = '0;
    logic [CNT_W-1:0] word_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic is_write;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
    logic last_access;
    logic rejected;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [1:0] cfg_data = '0;

    // Shadow copy of the block's configuration and buffer state
    logic [BANK_W-1:0] cur_bank = '0;
    logic cur_wide = 1'b1;
    logic cur_wen = 1'b1;
    logic [OFS_W-1:0] loaded_ofs = '0;

    access_t expected_bus[$];
    access_t seq_accesses[$];
    stim_row_t directed_rows[$];
    int errors = 0;
    bit calm = 1'b0;
    int stall_left = 0;

    nor_flash_command_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .target_offset (target_offset),
        .write_word    (write_word),
        .word_count    (word_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_write      (is_write),
        .bus_address   (bus_address),
        .bus_data      (bus_data),
        .last_access   (last_access),
        .rejected      (rejected),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [ADDR_W-1:0] base_addr();
        return 31'h6000_0000 + {cur_bank, 26'd0};
    endfunction

    // Command cycle address, shifted for a 16-bit device
    function automatic logic [ADDR_W-1:0] cmd_at(input logic [11:0] a);
        return base_addr() + (cur_wide ? {a, 1'b0} : {1'b0, a});
    endfunction

    function automatic void emit(input logic wr, input logic [ADDR_W-1:0] a,
                                 input logic [DATA_W-1:0] d);
        seq_accesses.push_back('{wr, a, d, 1'b0, 1'b0});
    endfunction

    function automatic void emit_unlock();
        emit(1'b1, cmd_at(CA_555), CD_UNLOCK1);
        emit(1'b1, cmd_at(CA_2AA), CD_UNLOCK2);
    endfunction

    // Build the bus accesses of one command into seq_accesses and advance the state
    function automatic void bus_accesses_for(input logic [3:0] op,
                                             input logic [OFS_W-1:0] ofs,
                                             input logic [DATA_W-1:0] word,
                                             input logic [CNT_W-1:0] cnt);
        logic [ADDR_W-1:0] plain;
        logic [CNT_W-1:0] n_words;
        seq_accesses = {};
        plain = base_addr() + {5'd0, ofs};
        if (op > OP_ERASE_CHIP)
            return;
        // Write protected: one refusal, state untouched
        if (op >= OP_PROGRAM && !cur_wen)
        begin
            seq_accesses.push_back('{1'b0, base_addr(), '0, 1'b1, 1'b1});
            return;
        end
        case (op)
            OP_TO_READ:
                emit(1'b1, base_addr(), CD_RESET);
            OP_ID:
            begin
                emit_unlock();
                emit(1'b1, cmd_at(CA_555), CD_AUTOSEL);
                emit(1'b0, cmd_at(12'h000), '0);
                emit(1'b0, cmd_at(12'h001), '0);
                emit(1'b0, cmd_at(12'h00E), '0);
                emit(1'b0, cmd_at(12'h00F), '0);
            end
            OP_CFI:
            begin
                emit(1'b1, cmd_at(CA_055), CD_CFI);
                emit(1'b0, cmd_at(12'h061), '0);
                emit(1'b0, cmd_at(12'h062), '0);
                emit(1'b0, cmd_at(12'h063), '0);
                emit(1'b0, cmd_at(12'h064), '0);
            end
            OP_RESET_READ:
            begin
                emit_unlock();
                emit(1'b1, cmd_at(CA_555), CD_RESET);
            end
            OP_READ:
                emit(1'b0, plain, '0);
            OP_PROGRAM:
            begin
                emit_unlock();
                emit(1'b1, cmd_at(CA_555), CD_PROGRAM);
                emit(1'b1, plain, word);
            end
            OP_BUF_START:
            begin
                // Clamp the count into 1..BUFFER_WORDS
                n_words = cnt;
                if (n_words == 0)
                    n_words = CNT_W'(1);
                if (n_words > BUFFER_WORDS)
                    n_words = CNT_W'(BUFFER_WORDS);
                emit_unlock();
                emit(1'b1, plain, CD_BUF_LOAD);
                emit(1'b1, plain, DATA_W'(n_words - 1'b1));
                loaded_ofs = ofs;
            end
            OP_BUF_WORD:
            begin
                emit(1'b1, plain, word);
                loaded_ofs = ofs;
            end
            OP_BUF_CONFIRM:
                emit(1'b1, base_addr() + {5'd0, loaded_ofs}, CD_BUF_PROG);
            OP_ERASE_BLOCK, OP_ERASE_CHIP:
            begin
                emit_unlock();
                emit(1'b1, cmd_at(CA_555), CD_ERASE);
                emit_unlock();
                if (op == OP_ERASE_BLOCK)
                    emit(1'b1, plain, CD_SECTOR);
                else
                    emit(1'b1, cmd_at(CA_555), CD_CHIP);
            end
            default:
                ;
        endcase
        seq_accesses[seq_accesses.size() - 1].last = 1'b1;
    endfunction

    function automatic stim_row_t cmd_row(input logic [3:0] op, input logic [OFS_W-1:0] ofs,
                                          input logic [DATA_W-1:0] word,
                                          input logic [CNT_W-1:0] cnt);
        stim_row_t r;
        r = '{default: '0};
        r.op = op;
        r.ofs = ofs;
        r.word = word;
        r.cnt = cnt;
        return r;
    endfunction

    // Single-access command whose result is written out by hand
    function automatic stim_row_t typed_row(input logic [3:0] op, input logic [OFS_W-1:0] ofs,
                                            input logic wr, input logic [ADDR_W-1:0] a,
                                            input logic [DATA_W-1:0] d, input logic rej);
        stim_row_t r;
        r = cmd_row(op, ofs, 16'h1234, 6'd3);
        r.typed = 1'b1;
        r.want = '{wr, a, d, 1'b1, rej};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [INDEX_W-1:0] idx, input logic [1:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [OFS_W-1:0] rand_ofs();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return OFS_W'($urandom);
        endcase
    endfunction

    // Send one request after a random gap and record its expected accesses
    task automatic issue_cmd(input logic [3:0] op, input logic [OFS_W-1:0] ofs,
                             input logic [DATA_W-1:0] word, input logic [CNT_W-1:0] cnt,
                             input bit typed, input access_t want);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        target_offset <= ofs;
        write_word <= word;
        word_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bus_accesses_for(op, ofs, word, cnt);
        if (typed)
            expected_bus.push_back(want);
        else
            foreach (seq_accesses[i])
                expected_bus.push_back(seq_accesses[i]);
    endtask

    // Hold off until every expected access has come out and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_bus.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BANK_SELECT:  cur_bank = val;
            REG_WIDE_BUS:     cur_wide = val[0];
            REG_WRITE_ENABLE: cur_wen = val[0];
            default:          ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver stall: draw a wait after every accepted access
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                stall_left = calm ? 0 : $urandom_range(0, 5);
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Compare each accepted access with the oldest expectation
    always @(posedge clk)
    begin
        access_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bus.size() == 0)
            begin
                $display("%0t: access with no request pending, expected none, actual %h %h %h %b %b",
                         $time, is_write, bus_address, bus_data, last_access, rejected);
                errors++;
            end
            else
            begin
                want = expected_bus.pop_front();
                check_field("is_write", 32'(want.is_write), 32'(is_write));
                check_field("bus_address", 32'(want.addr), 32'(bus_address));
                check_field("bus_data", 32'(want.data), 32'(bus_data));
                check_field("last_access", 32'(want.last), 32'(last_access));
                check_field("rejected", 32'(want.rejected), 32'(rejected));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [BANK_W-1:0] bank_set[6];
        logic wide_set[6];
        logic wen_set[6];
        int sent;
        int n_words;
        bit paused;
        logic [OFS_W-1:0] start_ofs;
        logic [CNT_W-1:0] cnt;

        bank_set = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
        wide_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        wen_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        // Directed table: reset values, extremes, every opcode, refusals
        directed_rows.push_back(typed_row(OP_TO_READ, '0, 1'b1, 31'h6000_0000, CD_RESET, 1'b0));
        directed_rows.push_back(typed_row(OP_BUF_CONFIRM, '0, 1'b1, 31'h6000_0000,
                                          CD_BUF_PROG, 1'b0));
        directed_rows.push_back(cmd_row(OP_ID, '0, '0, '0));
        directed_rows.push_back(cmd_row(OP_CFI, '1, '1, '1));
        directed_rows.push_back(cmd_row(OP_RESET_READ, '0, '0, '0));
        directed_rows.push_back(typed_row(OP_READ, '0, 1'b0, 31'h6000_0000, '0, 1'b0));
        directed_rows.push_back(typed_row(OP_READ, '1, 1'b0, 31'h63FF_FFFF, '0, 1'b0));
        directed_rows.push_back(cmd_row(OP_PROGRAM, '1, 16'hFFFF, '0));
        directed_rows.push_back(cmd_row(OP_BUF_START, '0, '0, 6'd0));
        directed_rows.push_back(cmd_row(OP_BUF_START, 26'h000_1000, '0, 6'd63));
        directed_rows.push_back(cmd_row(OP_BUF_WORD, 26'h3FF_FFFE, 16'h0000, '0));
        directed_rows.push_back(cmd_row(OP_BUF_CONFIRM, '0, '0, '0));
        directed_rows.push_back(cmd_row(OP_ERASE_BLOCK, '1, '0, '0));
        directed_rows.push_back(cmd_row(OP_ERASE_CHIP, '0, '0, '0));
        directed_rows.push_back(cmd_row(OP_UNUSED_LO, '1, '1, '1));
        directed_rows.push_back(cmd_row(OP_UNUSED_HI, '0, '0, '0));
        directed_rows.push_back(cfg_row(REG_BANK_SELECT, 2'd3));
        directed_rows.push_back(cfg_row(REG_WIDE_BUS, 2'd0));
        directed_rows.push_back(typed_row(OP_TO_READ, '0, 1'b1, 31'h6C00_0000, CD_RESET, 1'b0));
        directed_rows.push_back(cmd_row(OP_ID, '0, '0, '0));
        directed_rows.push_back(cmd_row(OP_BUF_START, 26'h155_5554, '0, 6'd32));
        directed_rows.push_back(cfg_row(REG_WRITE_ENABLE, 2'd0));
        directed_rows.push_back(typed_row(OP_PROGRAM, '1, 1'b0, 31'h6C00_0000, '0, 1'b1));
        directed_rows.push_back(typed_row(OP_BUF_START, '1, 1'b0, 31'h6C00_0000, '0, 1'b1));
        directed_rows.push_back(typed_row(OP_BUF_WORD, '1, 1'b0, 31'h6C00_0000, '0, 1'b1));
        directed_rows.push_back(typed_row(OP_BUF_CONFIRM, '0, 1'b0, 31'h6C00_0000, '0, 1'b1));
        directed_rows.push_back(typed_row(OP_ERASE_BLOCK, '1, 1'b0, 31'h6C00_0000, '0, 1'b1));
        directed_rows.push_back(typed_row(OP_ERASE_CHIP, '0, 1'b0, 31'h6C00_0000, '0, 1'b1));
        directed_rows.push_back(cmd_row(OP_READ, 26'h2AA_AAAA, '0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                issue_cmd(directed_rows[i].op, directed_rows[i].ofs, directed_rows[i].word,
                          directed_rows[i].cnt, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, one per configuration setting
        paused = 1'b0;
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_BANK_SELECT, bank_set[p]);
            write_reg(REG_WIDE_BUS, {1'b0, wide_set[p]});
            write_reg(REG_WRITE_ENABLE, {1'b0, wen_set[p]});
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // Let everything in flight come out once, mid-stream
                if (p == 3 && sent >= PHASE_ITEMS / 2 && !paused)
                begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 15) == 0)
                    calm = !calm;
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        // Buffer program: start, a run of words, confirm
                        n_words = $urandom_range(1, 5);
                        start_ofs = rand_ofs();
                        cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom) : CNT_W'(n_words);
                        issue_cmd(OP_BUF_START, start_ofs, DATA_W'($urandom), cnt, 1'b0, '0);
                        for (int w = 0; w < n_words; w++)
                            issue_cmd(OP_BUF_WORD, start_ofs + OFS_W'(2 * w), DATA_W'($urandom),
                                      CNT_W'($urandom), 1'b0, '0);
                        issue_cmd(OP_BUF_CONFIRM, rand_ofs(), DATA_W'($urandom),
                                  CNT_W'($urandom), 1'b0, '0);
                        sent += n_words + 2;
                    end
                    3:
                        issue_cmd(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), rand_ofs(),
                                  DATA_W'($urandom), CNT_W'($urandom), 1'b0, '0);
                    default:
                    begin
                        issue_cmd(4'($urandom_range(OP_TO_READ, OP_ERASE_CHIP)), rand_ofs(),
                                  DATA_W'($urandom), CNT_W'($urandom), 1'b0, '0);
                        sent++;
                    end
                endcase
            end
        end

        calm = 1'b0;
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
